### rtl/core/tlfc_pkg.sv
// ----------------------------------------------------------------------------
// tlfc_pkg
// shared types, codes and lookup functions of the thermal level capper
// ----------------------------------------------------------------------------
package tlfc_pkg;

    localparam int NUM_DOMAINS = 5;
    localparam int DOM_W       = 3;
    localparam int LVL_W       = 3;
    localparam int PCT_W       = 7;
    localparam int STEP_W      = 3;
    localparam int RADIX_BITS  = 4;
    localparam int REG_IDX_W   = 3;

    localparam logic [DOM_W-1:0] DOM_LITTLE = 3'd0;
    localparam logic [DOM_W-1:0] DOM_BIG    = 3'd1;
    localparam logic [DOM_W-1:0] DOM_GPU    = 3'd2;
    localparam logic [DOM_W-1:0] DOM_GPUBUS = 3'd3;
    localparam logic [DOM_W-1:0] DOM_DDR    = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_THRESH1   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESH2   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRESH3   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THRESH4   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HYST      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LITTLE_HW = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BIG_HW    = 3'd6;

    localparam logic [LVL_W-1:0] LVL_0 = 3'd0;
    localparam logic [LVL_W-1:0] LVL_1 = 3'd1;
    localparam logic [LVL_W-1:0] LVL_2 = 3'd2;
    localparam logic [LVL_W-1:0] LVL_3 = 3'd3;
    localparam logic [LVL_W-1:0] LVL_4 = 3'd4;

    localparam logic [PCT_W:0] DIVISOR = 8'd100;

    typedef logic [LVL_W-1:0] t_level;

    typedef struct packed {
        logic signed [31:0] thresh1;
        logic signed [31:0] thresh2;
        logic signed [31:0] thresh3;
        logic signed [31:0] thresh4;
        logic        [30:0] hyst;
        logic        [31:0] little_hw;
        logic        [31:0] big_hw;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [PCT_W-1:0] pct;
    } t_div_req;

    function automatic logic [PCT_W-1:0] pct_of(input t_level lvl);
        case (lvl)
            LVL_1:   pct_of = 7'd90;
            LVL_2:   pct_of = 7'd75;
            LVL_3:   pct_of = 7'd60;
            LVL_4:   pct_of = 7'd45;
            default: pct_of = 7'd100;
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] little_steps(input t_level lvl);
        case (lvl)
            LVL_1:   little_steps = 3'd1;
            LVL_2:   little_steps = 3'd2;
            LVL_3:   little_steps = 3'd3;
            LVL_4:   little_steps = 3'd4;
            default: little_steps = 3'd0;
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] big_steps(input t_level lvl);
        case (lvl)
            LVL_1:   big_steps = 3'd1;
            LVL_2:   big_steps = 3'd2;
            LVL_3:   big_steps = 3'd3;
            LVL_4:   big_steps = 3'd5;
            default: big_steps = 3'd0;
        endcase
    endfunction

endpackage

### rtl/core/tlfc_table_store.sv
// ----------------------------------------------------------------------------
// tlfc_table_store
// frequency table memory, one write and one registered read port, and the
// per-domain entry counts
// ----------------------------------------------------------------------------
module tlfc_table_store #(
    parameter int TABLE_DEPTH = 32,
    parameter int FREQ_BITS   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [tlfc_pkg::DOM_W-1:0]           i_wdom,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       i_widx,
    input  logic [FREQ_BITS-1:0]                 i_wdata,
    input  logic                                 i_wlast,
    input  logic [$clog2(tlfc_pkg::NUM_DOMAINS*TABLE_DEPTH)-1:0] i_raddr,
    output logic [FREQ_BITS-1:0]                 o_rdata,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     o_counts [tlfc_pkg::NUM_DOMAINS]
);
    import tlfc_pkg::*;

    localparam int MEM_DEPTH = NUM_DOMAINS * TABLE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);

    logic [FREQ_BITS-1:0] r_mem [MEM_DEPTH];
    logic [FREQ_BITS-1:0] r_rdata;
    logic [CNT_W-1:0]     r_cnt [NUM_DOMAINS];
    logic [ADDR_W-1:0]    w_waddr;

    assign w_waddr = ADDR_W'(i_wdom) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(i_widx);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[w_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DOMAINS; d++) begin
                r_cnt[d] <= '0;
            end
        end else if (i_we && i_wlast) begin
            r_cnt[i_wdom] <= CNT_W'(i_widx) + CNT_W'(1);
        end
    end

    assign o_rdata  = r_rdata;
    assign o_counts = r_cnt;

endmodule

### rtl/core/tlfc_div100.sv
// ----------------------------------------------------------------------------
// tlfc_div100
// shared percentage unit: floor(max * pct / 100), restoring division by the
// constant 100, four quotient bits per cycle
// ----------------------------------------------------------------------------
module tlfc_div100 #(
    parameter int FREQ_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tlfc_pkg::t_div_req     i_req,
    input  logic [FREQ_BITS-1:0]   i_mx,
    output logic                   o_done,
    output logic [FREQ_BITS-1:0]   o_quot
);
    import tlfc_pkg::*;

    localparam int PW      = FREQ_BITS + PCT_W;
    localparam int DIV_CYC = (PW + RADIX_BITS - 1) / RADIX_BITS;
    localparam int PADW    = DIV_CYC * RADIX_BITS;
    localparam int CYC_W   = $clog2(DIV_CYC + 1);

    logic [PADW-1:0]  r_work;
    logic [PCT_W-1:0] r_rem;
    logic [CYC_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [PADW-1:0]  w_work;
    logic [PCT_W-1:0] w_rem;
    logic [PCT_W:0]   w_t;

    always_comb begin
        w_work = r_work;
        w_rem  = r_rem;
        w_t    = '0;
        for (int k = 0; k < RADIX_BITS; k++) begin
            w_t    = {w_rem, w_work[PADW-1]};
            w_work = {w_work[PADW-2:0], 1'b0};
            if (w_t >= DIVISOR) begin
                w_rem     = PCT_W'(w_t - DIVISOR);
                w_work[0] = 1'b1;
            end else begin
                w_rem = w_t[PCT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CYC_W'(DIV_CYC);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CYC_W'(1);
            if (r_cnt == CYC_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= PADW'(i_mx) * PADW'(i_req.pct);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= w_work;
            r_rem  <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = FREQ_BITS'(r_work);

endmodule

### rtl/core/tlfc_seq.sv
// ----------------------------------------------------------------------------
// tlfc_seq
// sequencer: level decision with hysteresis, per-domain cap search over the
// table memory, and the result register
// ----------------------------------------------------------------------------
module tlfc_seq #(
    parameter int TABLE_DEPTH = 32,
    parameter int FREQ_BITS   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [31:0]                   i_temperature,
    input  tlfc_pkg::t_cfg                       i_cfg,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     i_counts [tlfc_pkg::NUM_DOMAINS],
    input  logic [FREQ_BITS-1:0]                 i_rdata,
    output logic [$clog2(tlfc_pkg::NUM_DOMAINS*TABLE_DEPTH)-1:0] o_raddr,
    output logic                                 o_busy,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [2:0]                           o_new_level,
    output logic [31:0]                          o_little_cap,
    output logic [31:0]                          o_big_cap,
    output logic [31:0]                          o_gpu_cap,
    output logic                                 o_gpu_cap_valid,
    output logic [31:0]                          o_gpubus_cap,
    output logic                                 o_gpubus_cap_valid,
    output logic [31:0]                          o_ddr_cap,
    output logic                                 o_ddr_cap_valid
);
    import tlfc_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_DOMAINS * TABLE_DEPTH);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LEVEL = 11'b000_0000_0010,
        S_HYST  = 11'b000_0000_0100,
        S_RMAX  = 11'b000_0000_1000,
        S_WMAX  = 11'b000_0001_0000,
        S_WSTEP = 11'b000_0010_0000,
        S_CPU   = 11'b000_0100_0000,
        S_DIV   = 11'b000_1000_0000,
        S_SCAN  = 11'b001_0000_0000,
        S_PICK  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic signed [31:0]   r_temp;
    t_level               r_level;
    t_level               r_prev;
    logic                 r_prev_vld;
    logic signed [33:0]   r_cool;
    logic [DOM_W-1:0]     r_dom;
    logic [FREQ_BITS-1:0] r_mx;
    logic [FREQ_BITS-1:0] r_pick;
    logic [FREQ_BITS-1:0] r_target;
    logic [FREQ_BITS-1:0] r_best;
    logic [FREQ_BITS-1:0] r_min;
    logic [CNT_W-1:0]     r_i;
    logic [FREQ_BITS-1:0] r_caps [NUM_DOMAINS];

    logic                 r_out_valid;
    t_level               r_out_level;
    logic [31:0]          r_out_cap [NUM_DOMAINS];
    logic                 r_out_gpu_vld;
    logic                 r_out_gpubus_vld;
    logic                 r_out_ddr_vld;

    logic [CNT_W-1:0]     w_cnt;
    logic [ADDR_W-1:0]    w_base;
    logic                 w_cpu;
    logic                 w_last_dom;
    logic [STEP_W-1:0]    w_steps;
    logic [CNT_W-1:0]     w_step_pos;
    logic [CNT_W-1:0]     w_last_pos;
    logic [FREQ_BITS-1:0] w_hw;
    logic [FREQ_BITS-1:0] w_eff;
    logic [FREQ_BITS-1:0] w_cpu_tmp;
    logic [FREQ_BITS-1:0] w_cpu_cap;
    logic [FREQ_BITS-1:0] w_pick_cap;
    t_level               w_level_raw;
    logic signed [31:0]   w_prev_th;
    logic                 w_hold;
    t_level               w_fin_level;
    logic                 w_no_change;
    logic                 w_hit;
    logic                 w_out_free;
    logic                 w_out_load;
    t_div_req             w_div_req;
    logic                 w_div_done;
    logic [FREQ_BITS-1:0] w_div_quot;

    tlfc_div100 #(
        .FREQ_BITS (FREQ_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_mx    (i_rdata),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign w_cnt      = i_counts[r_dom];
    assign w_base     = ADDR_W'(r_dom) * ADDR_W'(TABLE_DEPTH);
    assign w_cpu      = (r_dom == DOM_LITTLE) || (r_dom == DOM_BIG);
    assign w_last_dom = (r_dom == DOM_DDR);
    assign w_steps    = (r_dom == DOM_BIG) ? big_steps(r_level) : little_steps(r_level);
    assign w_last_pos = w_cnt - CNT_W'(1);
    assign w_step_pos = (CNT_W'(w_steps) < w_cnt) ? (w_last_pos - CNT_W'(w_steps)) : '0;

    // cpu cap bounded by the hardware maximum, unknown maximum taken from the table
    assign w_hw      = (r_dom == DOM_BIG) ? FREQ_BITS'(i_cfg.big_hw)
                                          : FREQ_BITS'(i_cfg.little_hw);
    assign w_eff     = (w_hw != '0) ? w_hw : r_mx;
    assign w_cpu_tmp = (r_pick == '0) ? w_eff : r_pick;
    assign w_cpu_cap = ((w_eff != '0) && (w_cpu_tmp > w_eff)) ? w_eff : w_cpu_tmp;

    assign w_pick_cap = (r_best != '0) ? r_best : r_min;
    assign w_hit      = (i_rdata <= r_target) && (i_rdata >= r_best);

    always_comb begin
        if (r_temp >= i_cfg.thresh4) begin
            w_level_raw = LVL_4;
        end else if (r_temp >= i_cfg.thresh3) begin
            w_level_raw = LVL_3;
        end else if (r_temp >= i_cfg.thresh2) begin
            w_level_raw = LVL_2;
        end else if (r_temp >= i_cfg.thresh1) begin
            w_level_raw = LVL_1;
        end else begin
            w_level_raw = LVL_0;
        end
    end

    always_comb begin
        case (r_prev)
            LVL_4:   w_prev_th = i_cfg.thresh4;
            LVL_3:   w_prev_th = i_cfg.thresh3;
            LVL_2:   w_prev_th = i_cfg.thresh2;
            default: w_prev_th = i_cfg.thresh1;
        endcase
    end

    assign w_hold      = r_prev_vld && (r_level < r_prev) && (34'(r_temp) > r_cool);
    assign w_fin_level = w_hold ? r_prev : r_level;
    assign w_no_change = r_prev_vld && (w_fin_level == r_prev);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = (r_state == S_OUT) && w_out_free;

    always_comb begin
        n_state       = r_state;
        o_raddr       = w_base + ADDR_W'(IDX_W'(w_last_pos));
        w_div_req     = '0;
        w_div_req.pct = pct_of(r_level);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LEVEL;
                end
            end
            S_LEVEL: begin
                n_state = S_HYST;
            end
            S_HYST: begin
                n_state = w_no_change ? S_IDLE : S_RMAX;
            end
            S_RMAX: begin
                if (w_cnt == '0) begin
                    n_state = w_cpu ? S_CPU : S_PICK;
                end else begin
                    n_state = S_WMAX;
                end
            end
            S_WMAX: begin
                if (w_cpu) begin
                    if (r_level != LVL_0) begin
                        o_raddr = w_base + ADDR_W'(IDX_W'(w_step_pos));
                        n_state = S_WSTEP;
                    end else begin
                        n_state = S_CPU;
                    end
                end else if (r_level == LVL_0) begin
                    n_state = S_PICK;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_WSTEP: begin
                n_state = S_CPU;
            end
            S_CPU, S_PICK: begin
                n_state = w_last_dom ? S_OUT : S_RMAX;
            end
            S_DIV: begin
                o_raddr = w_base;
                if (w_div_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_raddr = w_base + ADDR_W'(IDX_W'(r_i));
                if (r_i >= w_cnt) begin
                    n_state = S_PICK;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_HYST) && !w_no_change) begin
                r_prev_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_temp <= i_temperature;
                end
            end
            S_LEVEL: begin
                r_level <= w_level_raw;
                r_cool  <= 34'(w_prev_th) - 34'(i_cfg.hyst);
            end
            S_HYST: begin
                r_level <= w_fin_level;
                if (!w_no_change) begin
                    r_prev <= w_fin_level;
                end
                r_dom <= DOM_LITTLE;
            end
            S_RMAX: begin
                r_mx   <= '0;
                r_pick <= '0;
                r_best <= '0;
                r_min  <= '0;
            end
            S_WMAX: begin
                r_mx   <= i_rdata;
                r_pick <= i_rdata;
                r_best <= i_rdata;
                r_min  <= i_rdata;
            end
            S_WSTEP: begin
                r_pick <= i_rdata;
            end
            S_CPU: begin
                r_caps[r_dom] <= w_cpu_cap;
                if (!w_last_dom) begin
                    r_dom <= r_dom + DOM_W'(1);
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_target <= w_div_quot;
                    r_best   <= '0;
                    r_min    <= '1;
                    r_i      <= CNT_W'(1);
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    r_best <= i_rdata;
                end
                if (i_rdata < r_min) begin
                    r_min <= i_rdata;
                end
                if (r_i < w_cnt) begin
                    r_i <= r_i + CNT_W'(1);
                end
            end
            S_PICK: begin
                r_caps[r_dom] <= w_pick_cap;
                if (!w_last_dom) begin
                    r_dom <= r_dom + DOM_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_level <= r_level;
            for (int d = 0; d < NUM_DOMAINS; d++) begin
                r_out_cap[d] <= 32'(r_caps[d]);
            end
            r_out_gpu_vld    <= (r_caps[DOM_GPU] != '0);
            r_out_gpubus_vld <= (r_caps[DOM_GPUBUS] != '0);
            r_out_ddr_vld    <= (r_caps[DOM_DDR] != '0);
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_new_level        = r_out_level;
    assign o_little_cap       = r_out_cap[DOM_LITTLE];
    assign o_big_cap          = r_out_cap[DOM_BIG];
    assign o_gpu_cap          = r_out_cap[DOM_GPU];
    assign o_gpu_cap_valid    = r_out_gpu_vld;
    assign o_gpubus_cap       = r_out_cap[DOM_GPUBUS];
    assign o_gpubus_cap_valid = r_out_gpubus_vld;
    assign o_ddr_cap          = r_out_cap[DOM_DDR];
    assign o_ddr_cap_valid    = r_out_ddr_vld;

endmodule

### rtl/core/thermal_level_freq_capper_top.sv
// ----------------------------------------------------------------------------
// thermal_level_freq_capper_top
// thermal throttle level selection with hysteresis and per-domain frequency
// caps from five loaded frequency tables
//
//   channel  direction  handshake                      beat
//   in       sink       i_in_valid / o_in_stall        table entry or sample
//   out      source     o_out_valid / i_out_stall      level and five caps
//   cfg      sink       i_cfg_valid / o_cfg_ready      register index, data
//
// a table entry load is taken whenever the block is idle; a sample with no level
// change ends at the hysteresis check; a level change is bounded by the single
// table read port scanning the gpu, gpu bus and ddr tables and by the shared
// divide-by-100 unit
// o_in_stall stays high while a sample is in work; a waiting result beat
// holds the block only once the next result is ready
// synchronous active-low reset clears counts, level history and config
// ----------------------------------------------------------------------------
module thermal_level_freq_capper_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int FREQ_BITS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [2:0]         i_domain,
    input  logic [4:0]         i_entry_index,
    input  logic [31:0]        i_entry_freq,
    input  logic               i_entry_last,
    input  logic signed [31:0] i_temperature,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_new_level,
    output logic [31:0]        o_little_cap,
    output logic [31:0]        o_big_cap,
    output logic [31:0]        o_gpu_cap,
    output logic               o_gpu_cap_valid,
    output logic [31:0]        o_gpubus_cap,
    output logic               o_gpubus_cap_valid,
    output logic [31:0]        o_ddr_cap,
    output logic               o_ddr_cap_valid,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import tlfc_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_DOMAINS * TABLE_DEPTH);

    t_cfg                 r_cfg;
    logic                 w_busy;
    logic                 w_accept;
    logic                 w_load;
    logic                 w_start;
    logic [ADDR_W-1:0]    w_raddr;
    logic [FREQ_BITS-1:0] w_rdata;
    logic [CNT_W-1:0]     w_counts [NUM_DOMAINS];

    assign o_in_stall  = w_busy;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !w_busy;
    assign w_load      = w_accept && !i_func && (i_domain <= DOM_DDR)
                         && (32'(i_entry_index) < TABLE_DEPTH);
    assign w_start     = w_accept && i_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESH1:   r_cfg.thresh1   <= i_cfg_data;
                REG_THRESH2:   r_cfg.thresh2   <= i_cfg_data;
                REG_THRESH3:   r_cfg.thresh3   <= i_cfg_data;
                REG_THRESH4:   r_cfg.thresh4   <= i_cfg_data;
                REG_HYST:      r_cfg.hyst      <= i_cfg_data[30:0];
                REG_LITTLE_HW: r_cfg.little_hw <= i_cfg_data;
                REG_BIG_HW:    r_cfg.big_hw    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tlfc_table_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FREQ_BITS   (FREQ_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_load),
        .i_wdom   (i_domain),
        .i_widx   (IDX_W'(i_entry_index)),
        .i_wdata  (FREQ_BITS'(i_entry_freq)),
        .i_wlast  (i_entry_last),
        .i_raddr  (w_raddr),
        .o_rdata  (w_rdata),
        .o_counts (w_counts)
    );

    tlfc_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FREQ_BITS   (FREQ_BITS)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (w_start),
        .i_temperature      (i_temperature),
        .i_cfg              (r_cfg),
        .i_counts           (w_counts),
        .i_rdata            (w_rdata),
        .o_raddr            (w_raddr),
        .o_busy             (w_busy),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_new_level        (o_new_level),
        .o_little_cap       (o_little_cap),
        .o_big_cap          (o_big_cap),
        .o_gpu_cap          (o_gpu_cap),
        .o_gpu_cap_valid    (o_gpu_cap_valid),
        .o_gpubus_cap       (o_gpubus_cap),
        .o_gpubus_cap_valid (o_gpubus_cap_valid),
        .o_ddr_cap          (o_ddr_cap),
        .o_ddr_cap_valid    (o_ddr_cap_valid)
    );

endmodule

### verif/thermal_level_freq_capper_checker.sv
// ----------------------------------------------------------------------------
// thermal_level_freq_capper_checker
// watches the table/sample, result and register channels of the thermal level
// capper, keeps its own copy of the tables, level history and registers,
// works out the level and caps each sample should give and compares every
// result beat field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module thermal_level_freq_capper_checker #(
    parameter logic SAMPLE_FUNC = 1'b1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_func,
    input  logic [2:0]         i_domain,
    input  logic [4:0]         i_entry_index,
    input  logic [31:0]        i_entry_freq,
    input  logic               i_entry_last,
    input  logic signed [31:0] i_temperature,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_new_level,
    input  logic [31:0]        i_little_cap,
    input  logic [31:0]        i_big_cap,
    input  logic [31:0]        i_gpu_cap,
    input  logic               i_gpu_cap_valid,
    input  logic [31:0]        i_gpubus_cap,
    input  logic               i_gpubus_cap_valid,
    input  logic [31:0]        i_ddr_cap,
    input  logic               i_ddr_cap_valid,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_fails
);
    import tlfc_pkg::*;

    localparam int TABLE_SLOTS = 32;
    localparam int DUE_SLOTS   = 8;

    typedef struct packed {
        t_level      level;
        logic [31:0] little;
        logic [31:0] big;
        logic [31:0] gpu;
        logic        gpu_ok;
        logic [31:0] gpubus;
        logic        gpubus_ok;
        logic [31:0] ddr;
        logic        ddr_ok;
    } t_caps;

    t_caps              caps_due [DUE_SLOTS];
    int                 due_head = 0;
    int                 due_tail = 0;
    logic [31:0]        freq_tab [NUM_DOMAINS][TABLE_SLOTS];
    int unsigned        tab_len [NUM_DOMAINS];
    t_level             last_level;
    logic               level_known;
    logic signed [31:0] thresh [4];
    logic [30:0]        hyst;
    logic [31:0]        little_hw;
    logic [31:0]        big_hw;
    int                 mismatches = 0;

    int unsigned little_drop [5] = '{0, 1, 2, 3, 4};
    int unsigned big_drop [5]    = '{0, 1, 2, 3, 5};
    int unsigned share_pct [5]   = '{100, 90, 75, 60, 45};

    function automatic logic [31:0] table_top(input int d);
        if (tab_len[d] == 0) return 32'd0;
        return freq_tab[d][tab_len[d] - 1];
    endfunction

    function automatic logic [31:0] step_down(input int d, input int unsigned steps);
        int unsigned n;
        n = tab_len[d];
        if (n == 0) return 32'd0;
        if (steps >= n) return freq_tab[d][0];
        return freq_tab[d][n - 1 - steps];
    endfunction

    function automatic logic [31:0] frac_pick(input int d, input int unsigned pct);
        longint unsigned top_f, target, best, f;
        int unsigned     n, i;
        n = tab_len[d];
        top_f = table_top(d);
        target = (top_f / 100) * pct + ((top_f % 100) * pct) / 100;
        best = 0;
        for (i = 0; i < n; i++) begin
            f = freq_tab[d][i];
            if (f <= target && f >= best) best = f;
        end
        if (best == 0 && n > 0) begin
            best = freq_tab[d][0];
            for (i = 1; i < n; i++) begin
                if (freq_tab[d][i] < best) best = freq_tab[d][i];
            end
        end
        return best[31:0];
    endfunction

    function automatic logic [31:0] cpu_limit(input int d, input logic [31:0] hw,
                                              input t_level lvl, input int unsigned steps);
        logic [31:0] eff, cap;
        eff = (hw != 0) ? hw : table_top(d);
        cap = (lvl == LVL_0) ? table_top(d) : step_down(d, steps);
        if (cap == 0) cap = eff;
        if (eff != 0 && cap > eff) cap = eff;
        return cap;
    endfunction

    function automatic logic [31:0] shared_cap(input int d, input t_level lvl);
        if (tab_len[d] == 0) return 32'd0;
        return (lvl == LVL_0) ? table_top(d) : frac_pick(d, share_pct[lvl]);
    endfunction

    function automatic bit predict_sample(input logic signed [31:0] temp, output t_caps res);
        longint t, cool;
        longint th [4];
        t_level lvl;
        int     k;
        t = longint'(temp);
        for (k = 0; k < 4; k++) th[k] = longint'(thresh[k]);
        if (t >= th[3]) lvl = LVL_4;
        else if (t >= th[2]) lvl = LVL_3;
        else if (t >= th[1]) lvl = LVL_2;
        else if (t >= th[0]) lvl = LVL_1;
        else lvl = LVL_0;
        // cool-down only at or below the old level's threshold less the margin
        if (level_known && lvl < last_level) begin
            cool = th[last_level - 1] - longint'(hyst);
            if (t > cool) lvl = last_level;
        end
        if (level_known && lvl == last_level) return 1'b0;
        last_level = lvl;
        level_known = 1'b1;
        res.level = lvl;
        res.little = cpu_limit(int'(DOM_LITTLE), little_hw, lvl, little_drop[lvl]);
        res.big = cpu_limit(int'(DOM_BIG), big_hw, lvl, big_drop[lvl]);
        res.gpu = shared_cap(int'(DOM_GPU), lvl);
        res.gpu_ok = (res.gpu != 0);
        res.gpubus = shared_cap(int'(DOM_GPUBUS), lvl);
        res.gpubus_ok = (res.gpubus != 0);
        res.ddr = shared_cap(int'(DOM_DDR), lvl);
        res.ddr_ok = (res.ddr != 0);
        return 1'b1;
    endfunction

    function automatic void note_fail(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     field, want, want, got, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_caps want, got;
        if (!i_rst_n) begin
            due_head = 0;
            due_tail = 0;
            for (int d = 0; d < NUM_DOMAINS; d++) tab_len[d] = 0;
            level_known = 1'b0;
            last_level = LVL_0;
            for (int k = 0; k < 4; k++) thresh[k] = '0;
            hyst = '0;
            little_hw = '0;
            big_hw = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_THRESH1:   thresh[0] = i_cfg_data;
                    REG_THRESH2:   thresh[1] = i_cfg_data;
                    REG_THRESH3:   thresh[2] = i_cfg_data;
                    REG_THRESH4:   thresh[3] = i_cfg_data;
                    REG_HYST:      hyst = i_cfg_data[30:0];
                    REG_LITTLE_HW: little_hw = i_cfg_data;
                    REG_BIG_HW:    big_hw = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_new_level, i_little_cap, i_big_cap, i_gpu_cap, i_gpu_cap_valid,
                        i_gpubus_cap, i_gpubus_cap_valid, i_ddr_cap, i_ddr_cap_valid};
                if (due_tail == due_head) begin
                    note_fail("unexpected result beat, level", 32'd0, 32'(got.level));
                end else begin
                    want = caps_due[due_head % DUE_SLOTS];
                    due_head++;
                    if (got.level !== want.level)
                        note_fail("new_level", 32'(want.level), 32'(got.level));
                    if (got.little !== want.little) note_fail("little_cap", want.little, got.little);
                    if (got.big !== want.big) note_fail("big_cap", want.big, got.big);
                    if (got.gpu !== want.gpu) note_fail("gpu_cap", want.gpu, got.gpu);
                    if (got.gpu_ok !== want.gpu_ok)
                        note_fail("gpu_cap_valid", 32'(want.gpu_ok), 32'(got.gpu_ok));
                    if (got.gpubus !== want.gpubus)
                        note_fail("gpubus_cap", want.gpubus, got.gpubus);
                    if (got.gpubus_ok !== want.gpubus_ok)
                        note_fail("gpubus_cap_valid", 32'(want.gpubus_ok), 32'(got.gpubus_ok));
                    if (got.ddr !== want.ddr) note_fail("ddr_cap", want.ddr, got.ddr);
                    if (got.ddr_ok !== want.ddr_ok)
                        note_fail("ddr_cap_valid", 32'(want.ddr_ok), 32'(got.ddr_ok));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == SAMPLE_FUNC) begin
                    if (predict_sample(i_temperature, want)) begin
                        if (due_tail - due_head >= DUE_SLOTS) begin
                            note_fail("too many outstanding results", 32'(DUE_SLOTS),
                                      32'(due_tail - due_head));
                        end else begin
                            caps_due[due_tail % DUE_SLOTS] = want;
                            due_tail++;
                        end
                    end
                end else if (i_domain < NUM_DOMAINS) begin
                    freq_tab[i_domain][i_entry_index] = i_entry_freq;
                    if (i_entry_last) tab_len[i_domain] = int'(i_entry_index) + 1;
                end
            end
        end
        o_pending <= due_tail - due_head;
        o_fails <= mismatches;
    end

endmodule

### verif/thermal_level_freq_capper_top_test.sv
// ----------------------------------------------------------------------------
// thermal_level_freq_capper_top_test
// drives the thermal level capper with table loads and temperature samples:
// a directed opening over the field extremes and corner cases, then several
// phases of random table reloads, noise loads and samples aimed at the
// thresholds, each with its own register settings and idle/stall pattern;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module thermal_level_freq_capper_top_test;
    import tlfc_pkg::*;

    localparam logic        FUNC_LOAD      = 1'b0;
    localparam logic        FUNC_SAMPLE    = 1'b1;
    localparam logic [2:0]  DOM_BAD_LO     = 3'd5;
    localparam logic [2:0]  DOM_BAD_HI     = 3'd7;
    localparam int          DRAIN_CYCLES   = 200;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          PHASE_ITEMS    = 410;
    localparam longint      TEMP_MIN       = -64'sd2147483648;
    localparam longint      TEMP_MAX       = 64'sd2147483647;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_func = FUNC_LOAD;
    logic [2:0]         i_domain = DOM_LITTLE;
    logic [4:0]         i_entry_index = '0;
    logic [31:0]        i_entry_freq = '0;
    logic               i_entry_last = 1'b0;
    logic signed [31:0] i_temperature = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_new_level;
    logic [31:0]        o_little_cap;
    logic [31:0]        o_big_cap;
    logic [31:0]        o_gpu_cap;
    logic               o_gpu_cap_valid;
    logic [31:0]        o_gpubus_cap;
    logic               o_gpubus_cap_valid;
    logic [31:0]        o_ddr_cap;
    logic               o_ddr_cap_valid;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = REG_THRESH1;
    logic [31:0]        i_cfg_data = '0;

    int                 caps_pending;
    int                 fail_count;
    int unsigned        tx_idle_pct = 0;
    int unsigned        rx_stall_pct = 0;
    int unsigned        quiet_cycles = 0;
    logic [31:0]        written [NUM_DOMAINS] = '{default: '0};
    logic signed [31:0] thr_copy [4] = '{default: '0};
    logic [30:0]        hyst_copy = '0;

    always #1 i_clk = ~i_clk;

    thermal_level_freq_capper_top DUT (.*);

    thermal_level_freq_capper_checker #(.SAMPLE_FUNC(FUNC_SAMPLE)) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_domain           (i_domain),
        .i_entry_index      (i_entry_index),
        .i_entry_freq       (i_entry_freq),
        .i_entry_last       (i_entry_last),
        .i_temperature      (i_temperature),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_new_level        (o_new_level),
        .i_little_cap       (o_little_cap),
        .i_big_cap          (o_big_cap),
        .i_gpu_cap          (o_gpu_cap),
        .i_gpu_cap_valid    (o_gpu_cap_valid),
        .i_gpubus_cap       (o_gpubus_cap),
        .i_gpubus_cap_valid (o_gpubus_cap_valid),
        .i_ddr_cap          (o_ddr_cap),
        .i_ddr_cap_valid    (o_ddr_cap_valid),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_pending          (caps_pending),
        .o_fails            (fail_count)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("thermal_level_freq_capper_top_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_beat(input logic func, input logic [2:0] dom, input logic [4:0] idx,
                             input logic [31:0] freq, input logic last,
                             input logic signed [31:0] temp);
        i_in_valid <= 1'b1;
        i_func <= func;
        i_domain <= dom;
        i_entry_index <= idx;
        i_entry_freq <= freq;
        i_entry_last <= last;
        i_temperature <= temp;
        do @(posedge i_clk); while (o_in_stall);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_entry(input logic [2:0] dom, input logic [4:0] idx,
                              input logic [31:0] freq, input logic last);
        if (dom < NUM_DOMAINS) written[dom][idx] = 1'b1;
        push_beat(FUNC_LOAD, dom, idx, freq, last, $urandom);
    endtask

    task automatic send_sample(input logic signed [31:0] temp);
        push_beat(FUNC_SAMPLE, 3'($urandom_range(7)), 5'($urandom_range(31)), $urandom,
                  1'($urandom_range(1)), temp);
    endtask

    // wait for every outstanding result, then for any sample still in work
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (caps_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_config(input logic signed [31:0] t1, input logic signed [31:0] t2,
                               input logic signed [31:0] t3, input logic signed [31:0] t4,
                               input logic [30:0] hy, input logic [31:0] little_hw,
                               input logic [31:0] big_hw);
        write_reg(REG_THRESH1, t1);
        write_reg(REG_THRESH2, t2);
        write_reg(REG_THRESH3, t3);
        write_reg(REG_THRESH4, t4);
        write_reg(REG_HYST, {1'b0, hy});
        write_reg(REG_LITTLE_HW, little_hw);
        write_reg(REG_BIG_HW, big_hw);
        i_cfg_valid <= 1'b0;
        thr_copy = '{t1, t2, t3, t4};
        hyst_copy = hy;
    endtask

    // whole table in index order, last flag on the final entry
    task automatic reload_table(input logic [2:0] dom, input int unsigned n);
        logic [31:0] f, step_max;
        int unsigned shape, i;
        shape = $urandom_range(7);
        step_max = 32'hFFFF_FFFF >> $urandom_range(4, 31);
        f = (shape == 0) ? 32'd0 : $urandom_range(0, step_max);
        for (i = 0; i < n; i++) begin
            if (shape == 1) f = $urandom;
            else if (i > 0) f = f + $urandom_range(0, step_max);
            send_entry(dom, 5'(i), f, i == n - 1);
        end
    endtask

    function automatic logic signed [31:0] pick_temp();
        longint base, hy, t;
        int unsigned k;
        k = $urandom_range(3);
        base = thr_copy[k];
        hy = hyst_copy;
        case ($urandom_range(9))
            0:       t = $signed($urandom);
            1, 2:    t = base + $urandom_range(0, 2);
            3:       t = base - 1;
            4, 5:    t = base - hy + $urandom_range(0, 4) - 2;
            6:       t = base - hy - $urandom_range(1, 1000);
            default: t = base - $urandom_range(0, hyst_copy);
        endcase
        if (t < TEMP_MIN) t = TEMP_MIN;
        if (t > TEMP_MAX) t = TEMP_MAX;
        return t[31:0];
    endfunction

    task automatic random_items(input int unsigned quota);
        int unsigned done_items, pick, n;
        logic [2:0]  dom;
        logic [4:0]  idx;
        logic [31:0] below;
        logic        last;
        done_items = 0;
        while (done_items < quota) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                n = ($urandom_range(15) == 0) ? 32 : $urandom_range(1, 6);
                reload_table(3'($urandom_range(0, NUM_DOMAINS - 1)), n);
                done_items += n;
            end else if (pick < 20) begin
                dom = 3'($urandom_range(7));
                idx = 5'($urandom_range(31));
                below = (32'd1 << idx) - 32'd1;
                // a short table only where every entry below is already loaded
                last = (dom < NUM_DOMAINS) && $urandom_range(1) &&
                       ((written[dom] & below) == below);
                send_entry(dom, idx, $urandom, last);
                if (dom < NUM_DOMAINS) done_items++;
            end else begin
                send_sample(pick_temp());
                done_items++;
            end
        end
    endtask

    task automatic start_phase(input int phase);
        longint b;
        b = longint'($urandom_range(0, 200000)) - 100000;
        case (phase)
            0: begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
                load_config(32'(b), 32'(b + 1000), 32'(b + 2000 + $urandom_range(0, 3000)),
                            32'(b + 6000 + $urandom_range(0, 3000)),
                            31'($urandom_range(0, 500)), $urandom, 32'd0);
            end
            1: begin
                tx_idle_pct = 62;
                rx_stall_pct = 0;
                load_config(32'sh8000_0000, -32'sd1, 32'sd0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'd1);
            end
            2: begin
                tx_idle_pct = 0;
                rx_stall_pct = 62;
                load_config($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                            $urandom_range(0, 1000000), $urandom);
            end
            default: begin
                tx_idle_pct = 19;
                rx_stall_pct = 19;
                load_config(32'(b), 32'(b), 32'(b + $urandom_range(1, 50)), 32'(b + 100),
                            31'd0, 32'd0, $urandom_range(0, 100000));
            end
        endcase
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first sample with every table empty, then loads and level walk
        load_config(32'sd1000, 32'sd2000, 32'sd3000, 32'sd4000, 31'd100, 32'd0, 32'd0);
        send_sample(32'sh8000_0000);
        send_entry(DOM_LITTLE, 5'd0, 32'd300000, 1'b0);
        send_entry(DOM_LITTLE, 5'd1, 32'd600000, 1'b0);
        send_entry(DOM_LITTLE, 5'd2, 32'd900000, 1'b1);
        send_entry(DOM_BIG, 5'd0, 32'd500, 1'b0);
        send_entry(DOM_BIG, 5'd1, 32'hFFFF_FFFF, 1'b0);
        send_entry(DOM_BIG, 5'd2, 32'd100, 1'b1);
        send_entry(DOM_GPU, 5'd0, 32'd0, 1'b0);
        send_entry(DOM_GPU, 5'd1, 32'd1000, 1'b1);
        send_entry(DOM_BAD_LO, 5'd0, 32'd777, 1'b1);
        send_entry(DOM_BAD_HI, 5'd31, 32'hFFFF_FFFF, 1'b1);
        send_entry(DOM_GPUBUS, 5'd31, 32'hFFFF_FFFF, 1'b0);
        send_entry(DOM_DDR, 5'd0, 32'd200, 1'b0);
        send_entry(DOM_DDR, 5'd1, 32'd800, 1'b1);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sd3999);
        send_sample(32'sd3900);
        send_sample(32'sd2500);
        send_sample(32'sd1500);
        send_sample(32'sd1000);
        send_sample(32'sd0);
        send_sample(32'sd4000);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            start_phase(phase);
            random_items(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0) begin
            $display("thermal_level_freq_capper_top_test OK");
        end else begin
            $display("thermal_level_freq_capper_top_test NOT OK");
        end
        $finish;
    end

endmodule
